// File: rtl/tclc_pkg.sv
// ----------------------------------------------------------------------------
// tclc_pkg: shared types and constants for the two-channel lux calculator
// Field widths, fixed-point formats, status and register codes, and the
// eight-segment slope/offset tables for both package types.
// ----------------------------------------------------------------------------
package tclc_pkg;

   // raw counts and channel scaling
   localparam int CNT_W      = 16;
   localparam int FACTOR_W   = 19;   // largest factor is 0x7517 << 4
   localparam int CHAN_FRAC  = 10;
   localparam int SCALED_W   = CNT_W + FACTOR_W - CHAN_FRAC;

   // ratio and divider
   localparam int RATIO_FRAC = 9;
   localparam int DIV_W      = SCALED_W + RATIO_FRAC + 1;
   localparam int QUO_W      = 11;   // quotients from 2048 up are saturated
   localparam int RATIO_W    = QUO_W;

   // segment table
   localparam int SEG_N      = 8;
   localparam int SEG_W      = 3;
   localparam int BOUND_W    = 10;
   localparam int COEF_W     = 10;

   // lux arithmetic
   localparam int PROD_W     = SCALED_W + COEF_W;
   localparam int LUX_FRAC   = 14;
   localparam int LUX_W      = 21;
   localparam int RND_W      = PROD_W + 1 - LUX_FRAC;
   localparam int STATUS_W   = 2;

   // port widths
   localparam int REQ_DATA_W = 2 * CNT_W;
   localparam int RSP_DATA_W = ((LUX_W + 7) / 8) * 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;

   localparam logic [FACTOR_W-1:0] SCALE_SHORT  = FACTOR_W'(16'h7517);
   localparam logic [FACTOR_W-1:0] SCALE_MEDIUM = FACTOR_W'(16'h0fe7);
   localparam logic [FACTOR_W-1:0] SCALE_UNIT   = FACTOR_W'(1) << CHAN_FRAC;
   localparam logic [CNT_W-1:0]    SAT_LIMIT    = CNT_W'(4900);
   localparam logic [LUX_W-1:0]    LUX_MAX      = {LUX_W{1'b1}};
   localparam logic [PROD_W:0]     LUX_HALF     = (PROD_W+1)'(1) << (LUX_FRAC - 1);

   // integration time codes
   localparam logic [1:0] INTEG_13MS  = 2'd0;
   localparam logic [1:0] INTEG_101MS = 2'd1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_HIGH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_TIME = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PACKAGE_CS = CSR_IDX_W'(2);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_IR_ZERO = 2'd1,
      STATUS_SAT     = 2'd2
   } status_type;

   // scaled channel pair with its early status
   typedef struct packed {
      logic [SCALED_W-1:0] s0;
      logic [SCALED_W-1:0] s1;
      status_type          status;
   } scaled_type;

   // divider result: ovf means the rounded ratio is above every bound
   typedef struct packed {
      scaled_type       ctx;
      logic [QUO_W-1:0] quo;
      logic             ovf;
   } quo_type;

   typedef struct packed {
      logic [COEF_W-1:0] offs;
      logic [COEF_W-1:0] slope;
   } coef_type;

   // upper ratio bound of segment idx (last segment has none)
   function automatic logic [BOUND_W-1:0] seg_bound(input logic cs,
                                                    input logic [SEG_W-1:0] idx);
      logic [BOUND_W-1:0] b;
      b = '0;
      if (!cs) begin
         unique case (idx)
            3'd0:    b = 10'h040;
            3'd1:    b = 10'h080;
            3'd2:    b = 10'h0c0;
            3'd3:    b = 10'h100;
            3'd4:    b = 10'h138;
            3'd5:    b = 10'h19a;
            3'd6:    b = 10'h29a;
            default: b = {BOUND_W{1'b1}};
         endcase
      end else begin
         unique case (idx)
            3'd0:    b = 10'h043;
            3'd1:    b = 10'h085;
            3'd2:    b = 10'h0c8;
            3'd3:    b = 10'h10a;
            3'd4:    b = 10'h14d;
            3'd5:    b = 10'h19a;
            3'd6:    b = 10'h29a;
            default: b = {BOUND_W{1'b1}};
         endcase
      end
      return b;
   endfunction

   // offset and slope of segment idx; the last segment is all zero
   function automatic coef_type seg_coef(input logic cs, input logic [SEG_W-1:0] idx);
      coef_type c;
      c = '0;
      if (!cs) begin
         unique case (idx)
            3'd0:    c = '{offs: 10'h1f2, slope: 10'h1be};
            3'd1:    c = '{offs: 10'h214, slope: 10'h2d1};
            3'd2:    c = '{offs: 10'h23f, slope: 10'h37b};
            3'd3:    c = '{offs: 10'h270, slope: 10'h3fe};
            3'd4:    c = '{offs: 10'h16f, slope: 10'h1fc};
            3'd5:    c = '{offs: 10'h0d2, slope: 10'h0fb};
            3'd6:    c = '{offs: 10'h018, slope: 10'h012};
            default: c = '0;
         endcase
      end else begin
         unique case (idx)
            3'd0:    c = '{offs: 10'h204, slope: 10'h1ad};
            3'd1:    c = '{offs: 10'h228, slope: 10'h2c1};
            3'd2:    c = '{offs: 10'h253, slope: 10'h363};
            3'd3:    c = '{offs: 10'h282, slope: 10'h3df};
            3'd4:    c = '{offs: 10'h177, slope: 10'h1dd};
            3'd5:    c = '{offs: 10'h101, slope: 10'h127};
            3'd6:    c = '{offs: 10'h037, slope: 10'h02b};
            default: c = '0;
         endcase
      end
      return c;
   endfunction

endpackage

// File: rtl/tclc_scale.sv
// ----------------------------------------------------------------------------
// tclc_scale: channel scaling stage
// Multiplies both raw counts by the integration/gain factor and flags the
// infrared-zero and broadband-saturated cases. One register stage.
// ----------------------------------------------------------------------------
module tclc_scale import tclc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             gain_high,
   input  logic [1:0]       integ_time,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [CNT_W-1:0] broadband,
   input  logic [CNT_W-1:0] infrared,
   output logic             out_valid,
   input  logic             out_ready,
   output scaled_type       out_data
);

   localparam int P_W = CNT_W + FACTOR_W;

   logic [FACTOR_W-1:0] base;
   logic [FACTOR_W-1:0] factor;
   logic [P_W-1:0]      p0;
   logic [P_W-1:0]      p1;
   scaled_type          data_in;
   scaled_type          data_ff;
   logic                valid_in;
   logic                valid_ff;
   logic                advance;

   // channel factor from integration time and gain
   always_comb begin
      unique case (integ_time)
         INTEG_13MS:  base = SCALE_SHORT;
         INTEG_101MS: base = SCALE_MEDIUM;
         default:     base = SCALE_UNIT;
      endcase
      factor = gain_high ? base : (base << 4);
   end

   assign p0 = P_W'(broadband) * P_W'(factor);
   assign p1 = P_W'(infrared) * P_W'(factor);

   // scaled values and early status
   always_comb begin
      data_in.s0 = p0[CHAN_FRAC +: SCALED_W];
      data_in.s1 = p1[CHAN_FRAC +: SCALED_W];
      if (infrared == '0) begin
         data_in.status = STATUS_IR_ZERO;
      end else if (({1'b0, broadband} < {infrared, 1'b0}) && (broadband > SAT_LIMIT)) begin
         data_in.status = STATUS_SAT;
      end else begin
         data_in.status = STATUS_OK;
      end
   end

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/tclc_div.sv
// ----------------------------------------------------------------------------
// tclc_div: pipelined ratio divider
// Computes (s1 << 10) / s0 by restoring division, one quotient bit per
// stage. Quotients of 2048 and up only mark overflow; a zero s0 also lands
// there, which gives the same zero lux as the ratio of zero would.
// ----------------------------------------------------------------------------
module tclc_div import tclc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  scaled_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output quo_type    out_data
);

   localparam int N = QUO_W;

   quo_type          st_ff  [0:N];
   logic [DIV_W-1:0] rem_ff [0:N-1];
   logic             vld_ff [0:N];
   logic             rdy    [0:N+1];

   assign rdy[N+1]  = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[N];
   assign out_data  = st_ff[N];

   // handshake chain: a stage moves when empty or when its successor moves
   for (genvar k = 0; k <= N; k++) begin : g_ctl
      assign rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   // setup stage: overflow test and initial remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         st_ff[0].ctx <= in_data;
         st_ff[0].quo <= '0;
         st_ff[0].ovf <= {1'b0, in_data.s1} >= {in_data.s0, 1'b0};
         rem_ff[0]    <= {in_data.s1, {(RATIO_FRAC + 1){1'b0}}};
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 1; k <= N; k++) begin : g_step
      localparam int B = N - k;

      logic [DIV_W-1:0] dsh;
      logic [DIV_W:0]   trial;
      quo_type          st_in;
      logic [DIV_W-1:0] rem_in;

      always_comb begin
         dsh         = DIV_W'(st_ff[k-1].ctx.s0) << B;
         trial       = {1'b0, rem_ff[k-1]} - {1'b0, dsh};
         st_in       = st_ff[k-1];
         st_in.quo[B] = !trial[DIV_W];
         rem_in      = trial[DIV_W] ? rem_ff[k-1] : trial[DIV_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && vld_ff[k-1]) begin
            st_ff[k] <= st_in;
         end
      end

      if (k < N) begin : g_rem
         always_ff @(posedge clock) begin
            if (rdy[k] && vld_ff[k-1]) begin
               rem_ff[k] <= rem_in;
            end
         end
      end else begin : g_unused_rem
         logic [DIV_W-1:0] rem_last;
         assign rem_last = rem_in;
      end
   end

endmodule

// File: rtl/tclc_lux.sv
// ----------------------------------------------------------------------------
// tclc_lux: segment lookup and lux arithmetic
// Rounds the ratio and picks the segment coefficients, forms both products,
// then subtracts, clamps at zero, rounds, saturates and zeroes flagged
// items. Three register stages; the last one is the result output register.
// ----------------------------------------------------------------------------
module tclc_lux import tclc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             package_cs,
   input  logic             in_valid,
   output logic             in_ready,
   input  quo_type          in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [LUX_W-1:0] out_lux,
   output status_type       out_status
);

   // stage a: segment lookup
   logic [QUO_W:0]     ratio_sum;
   logic [RATIO_W-1:0] ratio;
   logic [SEG_W-1:0]   seg;
   coef_type           coef_in;
   coef_type           coef_ff;
   scaled_type         ctx_a_ff;
   logic               vld_a_ff;
   logic               rdy_a;

   // stage b: products
   logic [PROD_W-1:0]  pos_in;
   logic [PROD_W-1:0]  neg_in;
   logic [PROD_W-1:0]  pos_ff;
   logic [PROD_W-1:0]  neg_ff;
   status_type         status_b_ff;
   logic               vld_b_ff;
   logic               rdy_b;

   // stage c: result
   logic [PROD_W-1:0]  diff;
   logic [PROD_W:0]    rounded;
   logic [RND_W-1:0]   shifted;
   logic [LUX_W-1:0]   lux_in;
   logic [LUX_W-1:0]   lux_ff;
   status_type         status_c_ff;
   logic               vld_c_ff;
   logic               rdy_c;

   assign rdy_c    = !vld_c_ff || out_ready;
   assign rdy_b    = !vld_b_ff || rdy_c;
   assign rdy_a    = !vld_a_ff || rdy_b;
   assign in_ready = rdy_a;

   // rounded ratio and segment select
   always_comb begin
      ratio_sum = {1'b0, in_data.quo} + (QUO_W+1)'(1);
      ratio     = ratio_sum[QUO_W:1];
      seg       = SEG_W'(SEG_N - 1);
      for (int i = SEG_N - 2; i >= 0; i--) begin
         if (ratio <= RATIO_W'(seg_bound(package_cs, SEG_W'(i)))) begin
            seg = SEG_W'(i);
         end
      end
      if (in_data.ovf) begin
         seg = SEG_W'(SEG_N - 1);
      end
      coef_in = seg_coef(package_cs, seg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (rdy_a) begin
         vld_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         coef_ff  <= coef_in;
         ctx_a_ff <= in_data.ctx;
      end
   end

   // offset and slope products
   assign pos_in = PROD_W'(ctx_a_ff.s0) * PROD_W'(coef_ff.offs);
   assign neg_in = PROD_W'(ctx_a_ff.s1) * PROD_W'(coef_ff.slope);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (rdy_b) begin
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_b && vld_a_ff) begin
         pos_ff      <= pos_in;
         neg_ff      <= neg_in;
         status_b_ff <= ctx_a_ff.status;
      end
   end

   // clamp, round, scale down and saturate
   always_comb begin
      diff    = (pos_ff > neg_ff) ? (pos_ff - neg_ff) : '0;
      rounded = {1'b0, diff} + LUX_HALF;
      shifted = rounded[PROD_W:LUX_FRAC];
      if (status_b_ff != STATUS_OK) begin
         lux_in = '0;
      end else if (shifted > RND_W'(LUX_MAX)) begin
         lux_in = LUX_MAX;
      end else begin
         lux_in = shifted[LUX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else if (rdy_c) begin
         vld_c_ff <= vld_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_c && vld_b_ff) begin
         lux_ff      <= lux_in;
         status_c_ff <= status_b_ff;
      end
   end

   assign out_valid  = vld_c_ff;
   assign out_lux    = lux_ff;
   assign out_status = status_c_ff;

endmodule

// File: rtl/two_channel_lux_calc_unit.sv
// Two-channel lux calculator. Each item on req_ carries a broadband and an
// infrared photodiode count; exactly one item comes back on rsp_ with the
// lux value and a status code (0 valid, 1 infrared zero, 2 broadband
// saturated; lux is zero whenever status is nonzero). The block takes one
// item per clock while the result side accepts; each passes through channel
// scaling, the ratio divider (a setup stage and eleven restoring steps, one
// quotient bit each), and the segment lookup, multiply and rounding stages,
// the last of which is the output register. A stage stalls only when it
// is full and its successor cannot move, so empty stages keep filling while
// a result waits. The user must write gain, integration time and package
// type through csr_ only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
// two_channel_lux_calc_unit: top level of the lux calculator
// Configuration registers, stream ports, and the three pipeline sections.
// ----------------------------------------------------------------------------
module two_channel_lux_calc_unit import tclc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] broadband_count, [31:16] infrared_count
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [20:0] lux_value, [23:21] zero
   output logic [STATUS_W-1:0]   rsp_tuser,  // [1:0] status
   // configuration writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic       gain_high_ff;
   logic [1:0] integ_time_ff;
   logic       package_cs_ff;

   logic       sc_valid;
   logic       sc_ready;
   scaled_type sc_data;
   logic       dv_valid;
   logic       dv_ready;
   quo_type    dv_data;

   logic [LUX_W-1:0] lux;
   status_type       status;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_high_ff  <= 1'b0;
         integ_time_ff <= INTEG_13MS;
         package_cs_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN_HIGH:  gain_high_ff  <= csr_wdata[0];
            CSR_INTEG_TIME: integ_time_ff <= csr_wdata[1:0];
            CSR_PACKAGE_CS: package_cs_ff <= csr_wdata[0];
            default:        ;
         endcase
      end
   end

   tclc_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .gain_high  (gain_high_ff),
      .integ_time (integ_time_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .broadband  (req_tdata[CNT_W-1:0]),
      .infrared   (req_tdata[2*CNT_W-1:CNT_W]),
      .out_valid  (sc_valid),
      .out_ready  (sc_ready),
      .out_data   (sc_data)
   );

   tclc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sc_valid),
      .in_ready  (sc_ready),
      .in_data   (sc_data),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_data  (dv_data)
   );

   tclc_lux u_lux (
      .clock      (clock),
      .reset      (reset),
      .package_cs (package_cs_ff),
      .in_valid   (dv_valid),
      .in_ready   (dv_ready),
      .in_data    (dv_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_lux    (lux),
      .out_status (status)
   );

   assign rsp_tdata = RSP_DATA_W'(lux);
   assign rsp_tuser = status;

   // a flagged result never carries a lux value
   a_flag_zero_lux: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != STATUS_OK)) |-> (rsp_tdata[LUX_W-1:0] == '0))
      else $error("nonzero lux with nonzero status");

   // input backpressure only when the whole pipeline is full and stalled
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while output side can move");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// File: test/two_channel_lux_calc_unit_test.sv
// ----------------------------------------------------------------------------
// two_channel_lux_calc_unit_test: self-checking bench for the lux calculator
// Drives broadband/infrared count pairs through the req_ stream and checks
// every rsp_ item against a local lux predictor. Covers count extremes, the
// infrared-zero and saturation cases, every register setting, and long
// random runs with bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_channel_lux_calc_unit_test;
   import tclc_pkg::*;

   localparam int LIMIT_CYCLES  = 500000;
   localparam int TAIL_CYCLES   = 24;      // pipeline is 16 deep
   localparam int MAX_REPORTS   = 10;
   localparam int SWEEP_ITEMS   = 20;
   localparam int PHASE_ITEMS   = 160;
   localparam int RANDOM_PHASES = 8;

   // register index that maps to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);

   // channel factors, 10 fractional bits
   localparam logic [63:0] FACTOR_13MS  = 64'h7517;
   localparam logic [63:0] FACTOR_101MS = 64'h0fe7;
   localparam logic [63:0] FACTOR_UNIT  = 64'd1024;
   localparam logic [63:0] SAT_COUNT    = 64'd4900;
   localparam logic [63:0] LUX_CEILING  = 64'd2097151;

   typedef struct packed {
      logic [LUX_W-1:0] lux;
      status_type       status;
   } lux_reading_type;

   typedef struct packed {
      logic [11:0] bound;
      logic [9:0]  offs;
      logic [9:0]  slope;
   } segment_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // [15:0] broadband_count, [31:16] infrared_count
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // [20:0] lux_value, [23:21] zero
   logic [STATUS_W-1:0]   rsp_tuser;       // [1:0] status
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the configuration
   logic       gain_sel  = 1'b0;
   logic [1:0] integ_sel = 2'd0;
   logic       cs_sel    = 1'b0;

   lux_reading_type expected_lux_q[$];

   int cycle_count    = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int settings_count = 0;
   int ok_count       = 0;
   int ir_zero_count  = 0;
   int sat_count      = 0;
   int burst_left     = 0;
   bit steady_sender  = 1'b0;

   // receiver stall pattern state
   int        stall_left = 0;
   int        stall_mode = 0;
   bit [15:0] stall_bits = '0;

   two_channel_lux_calc_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_lux_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // slope/offset segments; the last one has no bound and zero coefficients
   function automatic segment_type lux_segment(input logic cs, input int idx);
      segment_type seg;
      seg = '0;
      if (!cs) begin
         case (idx)
            0: seg = '{bound: 12'h040, offs: 10'h1f2, slope: 10'h1be};
            1: seg = '{bound: 12'h080, offs: 10'h214, slope: 10'h2d1};
            2: seg = '{bound: 12'h0c0, offs: 10'h23f, slope: 10'h37b};
            3: seg = '{bound: 12'h100, offs: 10'h270, slope: 10'h3fe};
            4: seg = '{bound: 12'h138, offs: 10'h16f, slope: 10'h1fc};
            5: seg = '{bound: 12'h19a, offs: 10'h0d2, slope: 10'h0fb};
            6: seg = '{bound: 12'h29a, offs: 10'h018, slope: 10'h012};
            default: seg = '0;
         endcase
      end else begin
         case (idx)
            0: seg = '{bound: 12'h043, offs: 10'h204, slope: 10'h1ad};
            1: seg = '{bound: 12'h085, offs: 10'h228, slope: 10'h2c1};
            2: seg = '{bound: 12'h0c8, offs: 10'h253, slope: 10'h363};
            3: seg = '{bound: 12'h10a, offs: 10'h282, slope: 10'h3df};
            4: seg = '{bound: 12'h14d, offs: 10'h177, slope: 10'h1dd};
            5: seg = '{bound: 12'h19a, offs: 10'h101, slope: 10'h127};
            6: seg = '{bound: 12'h29a, offs: 10'h037, slope: 10'h02b};
            default: seg = '0;
         endcase
      end
      return seg;
   endfunction

   // expected result for one count pair under the current shadow settings
   function automatic lux_reading_type predict_lux(input logic [15:0] bb,
                                                   input logic [15:0] ir);
      lux_reading_type res;
      segment_type     seg;
      logic [63:0]     c0, c1, factor, s0, s1, ratio, pos, neg, diff, lux;
      int              idx;
      c0  = 64'(bb);
      c1  = 64'(ir);
      res = '{lux: '0, status: STATUS_OK};
      if (c1 == 0) begin
         res.status = STATUS_IR_ZERO;
      end else if ((c0 / c1) < 2 && c0 > SAT_COUNT) begin
         res.status = STATUS_SAT;
      end else begin
         if (integ_sel == INTEG_13MS)
            factor = FACTOR_13MS;
         else if (integ_sel == INTEG_101MS)
            factor = FACTOR_101MS;
         else
            factor = FACTOR_UNIT;
         if (!gain_sel)
            factor = factor << 4;
         s0 = (c0 * factor) >> 10;
         s1 = (c1 * factor) >> 10;
         // rounded ratio, 9 fractional bits; zero broadband gives zero
         ratio = 0;
         if (s0 != 0)
            ratio = (s1 << 10) / s0;
         ratio = (ratio + 1) >> 1;
         idx = 0;
         while (idx < 7 && ratio > 64'(lux_segment(cs_sel, idx).bound))
            idx++;
         seg  = lux_segment(cs_sel, idx);
         pos  = s0 * 64'(seg.offs);
         neg  = s1 * 64'(seg.slope);
         diff = (pos > neg) ? pos - neg : 64'd0;
         lux  = (diff + 64'd8192) >> 14;
         if (lux > LUX_CEILING)
            lux = LUX_CEILING;
         res.lux = lux[LUX_W-1:0];
      end
      return res;
   endfunction

   // result sink: picks a new random stall pattern whenever the last one runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_bits = 16'($urandom);
         stall_left = 64;
      end
      stall_left = stall_left - 1;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= stall_bits[stall_left % 16];
         2:       rsp_tready <= stall_bits[stall_left % 16] | stall_bits[(stall_left + 5) % 16];
         default: rsp_tready <= (stall_left % 4) == 0;
      endcase
   end

   // result checker
   always @(posedge clock) begin : check_result
      lux_reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_lux_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result %0d arrived with nothing expected: lux %0d status %0d",
                        results_seen, rsp_tdata[LUX_W-1:0], rsp_tuser);
         end else begin
            want = expected_lux_q.pop_front();
            case (want.status)
               STATUS_OK:      ok_count++;
               STATUS_IR_ZERO: ir_zero_count++;
               default:        sat_count++;
            endcase
            if (rsp_tdata[LUX_W-1:0] !== want.lux || rsp_tuser !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result %0d: expected lux %0d status %0d, got lux %0d status %0d",
                           results_seen, want.lux, want.status, rsp_tdata[LUX_W-1:0],
                           rsp_tuser);
            end
         end
      end
   end

   // send one count pair, then maybe close the burst with a gap
   task automatic send_counts(input logic [15:0] bb, input logic [15:0] ir);
      req_tdata  <= {ir, bb};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_lux_q.push_back(predict_lux(bb, ir));
      items_sent++;
      if (!steady_sender) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   // hold the input and let every outstanding result come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_lux_q.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_GAIN_HIGH:  gain_sel  = val[0];
         CSR_INTEG_TIME: integ_sel = val[1:0];
         CSR_PACKAGE_CS: cs_sel    = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // program all registers; spare upper data bits are randomized
   task automatic apply_settings(input logic gain, input logic [1:0] integ, input logic cs);
      wait_results_drained();
      write_reg(CSR_GAIN_HIGH, {1'($urandom), gain});
      write_reg(CSR_INTEG_TIME, integ);
      write_reg(CSR_PACKAGE_CS, {1'($urandom), cs});
      // unused index must not disturb anything
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      settings_count++;
   endtask

   // random count pair aimed at all segments and both error cases
   function automatic logic [31:0] pick_counts();
      logic [15:0] bb, ir;
      logic [31:0] scaled;
      int          kind;
      kind = $urandom_range(0, 99);
      bb   = 16'($urandom) & 16'((32'd1 << $urandom_range(1, 16)) - 1);
      if (kind < 8) begin
         ir = '0;
      end else if (kind < 23) begin
         bb = 16'($urandom);
         ir = 16'($urandom);
      end else if (kind < 33) begin
         // straddle the saturation limit and the 2:1 quotient edge
         bb = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(4895, 4905))
                                          : 16'($urandom_range(4901, 65535));
         ir = (bb >> 1) - 16'd1 + 16'($urandom_range(0, 3));
      end else begin
         // infrared as a fraction of broadband, 9 fractional bits
         scaled = (32'(bb) * $urandom_range(0, 800)) >> 9;
         ir     = (scaled > 32'hffff) ? 16'hffff : scaled[15:0];
      end
      return {ir, bb};
   endfunction

   task automatic send_random(input int count);
      logic [31:0] pair;
      for (int n = 0; n < count; n++) begin
         pair = pick_counts();
         send_counts(pair[15:0], pair[31:16]);
      end
   endtask

   // count extremes under reset settings
   task automatic test_count_extremes();
      send_counts(16'd0, 16'd0);
      send_counts(16'hffff, 16'd0);
      send_counts(16'd0, 16'hffff);
      send_counts(16'hffff, 16'hffff);
      send_counts(16'hffff, 16'd1);
      send_counts(16'd1, 16'd1);
      send_counts(16'd1, 16'hffff);
      send_counts(16'haaaa, 16'h5555);
      send_counts(16'h5555, 16'h2aaa);
      wait_results_drained();
   endtask

   // saturation edges, zero broadband, ratio past the table, negative lux
   task automatic test_special_cases();
      send_counts(16'd4900, 16'd4900);   // not above the limit
      send_counts(16'd4901, 16'd2451);   // quotient 1, saturated
      send_counts(16'd4901, 16'd4900);
      send_counts(16'd9802, 16'd4901);   // quotient 2, valid
      send_counts(16'd9801, 16'd4901);   // quotient 1, saturated
      apply_settings(1'b1, 2'd2, 1'b0);  // unit factor, scaled equals raw
      send_counts(16'd0, 16'd1);         // zero scaled broadband
      send_counts(16'd1000, 16'd1400);   // ratio beyond the last bound
      send_counts(16'd1000, 16'd1290);   // last real segment, T table
      apply_settings(1'b1, 2'd2, 1'b1);
      send_counts(16'd1000, 16'd1290);   // slope term wins, clamped to zero
      send_counts(16'd1000, 16'd1295);
      send_counts(16'd1000, 16'd1400);
      wait_results_drained();
   endtask

   // every combination of gain, integration time and package
   task automatic test_register_sweep();
      for (int g = 0; g < 2; g++)
         for (int t = 0; t < 4; t++)
            for (int c = 0; c < 2; c++) begin
               apply_settings(g[0], t[1:0], c[0]);
               steady_sender = (t == 3);
               send_random(SWEEP_ITEMS);
            end
      steady_sender = 1'b0;
      wait_results_drained();
   endtask

   // long random runs, one random setting per phase, with a mid-phase drain
   task automatic test_random_settings();
      int split;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_settings(1'($urandom), 2'($urandom), 1'($urandom));
         steady_sender = ($urandom_range(0, 3) == 0);
         split = $urandom_range(10, PHASE_ITEMS - 10);
         send_random(split);
         wait_results_drained();
         send_random(PHASE_ITEMS - split);
      end
      steady_sender = 1'b0;
      wait_results_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_count_extremes();
      test_special_cases();
      test_register_sweep();
      test_random_settings();

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_lux_q.size() != 0) begin
         mismatch_count += expected_lux_q.size();
         $display("%0d expected results never arrived", expected_lux_q.size());
      end

      $display("Sent %0d count pairs across %0d register settings; checked %0d results.",
               items_sent, settings_count, results_seen);
      $display("Outcomes: %0d valid lux, %0d infrared zero, %0d saturated; %0d mismatches.",
               ok_count, ir_zero_count, sat_count, mismatch_count);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
